### hw/rtl/rdc_pkg.sv
// rdc_pkg: shared constants, types and helpers for the radix digit converter
// no dependencies; imported by rdc_datapath, rdc_ctrl and radix_digit_converter
package rdc_pkg;

  localparam int unsigned VALUE_BITS_DEF = 31;
  localparam int unsigned BASE_W         = 4;
  localparam int unsigned DIGIT_W        = 4;
  localparam int unsigned CHUNK          = 8;
  localparam logic [BASE_W-1:0] BASE_MIN = 4'd2;
  localparam logic [BASE_W-1:0] BASE_MAX = 4'd10;

  typedef struct packed {
    logic load;
    logic div_step;
    logic pop;
    logic err;
  } rdc_cmd_t;

  typedef struct packed {
    logic in_bad;
    logic in_zero;
    logic step_first;
    logic quot_zero;
    logic cnt_one;
    logic out_free;
  } rdc_stat_t;

  function automatic logic base_bad(input logic [BASE_W-1:0] b);
    return (b < BASE_MIN) || (b > BASE_MAX);
  endfunction

endpackage

### hw/rtl/rdc_ram.sv
// rdc_ram: generic single-write, single-read ram with registered read data
// no dependencies
module rdc_ram #(
  parameter int unsigned WIDTH = 4,
  parameter int unsigned DEPTH = 31,
  localparam int unsigned AW   = (DEPTH > 1) ? $clog2(DEPTH) : 1
) (
  input  logic             clk,
  input  logic             wr_en,
  input  logic [AW-1:0]    wr_addr,
  input  logic [WIDTH-1:0] wr_data,
  input  logic             rd_en,
  input  logic [AW-1:0]    rd_addr,
  output logic [WIDTH-1:0] rd_data
);

  logic [WIDTH-1:0] mem [DEPTH];

  always_ff @(posedge clk) begin
    if (wr_en) begin
      mem[wr_addr] <= wr_data;
    end
    if (rd_en) begin
      rd_data <= mem[rd_addr];
    end
  end

endmodule

### hw/rtl/rdc_datapath.sv
// rdc_datapath: chunked divider, digit stack and output register
// depends on rdc_pkg and rdc_ram
module rdc_datapath
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF
) (
  input  logic                  clk,
  input  logic                  rst,
  input  rdc_cmd_t              cmd,
  output rdc_stat_t             stat,
  input  logic [VALUE_BITS-1:0] in_value,
  input  logic [BASE_W-1:0]     in_base,
  input  logic                  out_ready,
  output logic                  out_valid,
  output logic [DIGIT_W-1:0]    out_digit,
  output logic                  out_last,
  output logic                  out_bad
);

  localparam int unsigned STEPS = (VALUE_BITS + CHUNK - 1) / CHUNK;
  localparam int unsigned W     = STEPS * CHUNK;
  localparam int unsigned SW    = (STEPS > 1) ? $clog2(STEPS) : 1;
  localparam int unsigned AW    = (VALUE_BITS > 1) ? $clog2(VALUE_BITS) : 1;
  localparam int unsigned CW    = $clog2(VALUE_BITS + 1);

  logic [W-1:0]       work;
  logic [W-1:0]       work_next;
  logic [BASE_W-1:0]  base;
  logic [DIGIT_W-1:0] rem;
  logic [DIGIT_W-1:0] rem_next;
  logic [SW-1:0]      step;
  logic [CW-1:0]      count;
  logic               last_step;
  logic               push;
  logic [DIGIT_W-1:0] ram_q;

  assign last_step = (step == SW'(STEPS - 1));
  assign push      = cmd.div_step && last_step;

  // restoring division of CHUNK quotient bits per cycle
  always_comb begin
    logic [DIGIT_W:0] t;
    logic [DIGIT_W-1:0] r;
    logic [CHUNK-1:0] qb;
    r  = rem;
    qb = '0;
    for (int i = 0; i < CHUNK; i++) begin
      t = {r, work[W-1-i]};
      if (t >= {1'b0, base}) begin
        qb[CHUNK-1-i] = 1'b1;
        t = t - {1'b0, base};
      end
      r = t[DIGIT_W-1:0];
    end
    rem_next  = r;
    work_next = (work << CHUNK) | W'(qb);
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      step      <= '0;
      count     <= '0;
      out_valid <= 1'b0;
      out_bad   <= 1'b0;
      out_last  <= 1'b0;
    end else begin
      if (cmd.load) begin
        step  <= '0;
        count <= '0;
      end else if (cmd.div_step) begin
        step <= last_step ? '0 : step + SW'(1);
        if (last_step) begin
          count <= count + CW'(1);
        end
      end else if (cmd.pop) begin
        count <= count - CW'(1);
      end

      if (cmd.pop) begin
        out_valid <= 1'b1;
        out_bad   <= 1'b0;
        out_last  <= (count == CW'(1));
      end else if (cmd.err) begin
        out_valid <= 1'b1;
        out_bad   <= 1'b1;
        out_last  <= 1'b1;
      end else if (out_ready) begin
        out_valid <= 1'b0;
      end
    end
  end

  always_ff @(posedge clk) begin
    if (cmd.load) begin
      work <= W'(in_value);
      base <= in_base;
      rem  <= '0;
    end else if (cmd.div_step) begin
      work <= work_next;
      rem  <= last_step ? '0 : rem_next;
    end
  end

  rdc_ram #(
    .WIDTH(DIGIT_W),
    .DEPTH(VALUE_BITS)
  ) u_stack (
    .clk    (clk),
    .wr_en  (push),
    .wr_addr(count[AW-1:0]),
    .wr_data(rem_next),
    .rd_en  (cmd.pop),
    .rd_addr(AW'(count - CW'(1))),
    .rd_data(ram_q)
  );

  assign out_digit = out_bad ? '0 : ram_q;

  assign stat.in_bad     = base_bad(in_base);
  assign stat.in_zero    = (in_value == '0);
  assign stat.step_first = (step == '0);
  assign stat.quot_zero  = (work == '0);
  assign stat.cnt_one    = (count == CW'(1));
  assign stat.out_free   = !out_valid || out_ready;

endmodule

### hw/rtl/rdc_ctrl.sv
// rdc_ctrl: sequencer for divide, pop and error phases
// depends on rdc_pkg
module rdc_ctrl
  import rdc_pkg::*;
(
  input  logic      clk,
  input  logic      rst,
  input  logic      in_valid,
  output logic      in_ready,
  input  rdc_stat_t stat,
  output rdc_cmd_t  cmd
);

  typedef enum logic [1:0] {
    ST_IDLE,
    ST_DIV,
    ST_EMIT,
    ST_ERR
  } state_t;

  state_t state;
  state_t state_next;

  assign in_ready = (state == ST_IDLE);

  always_comb begin
    cmd        = '0;
    state_next = state;
    case (state)
      ST_IDLE: begin
        if (in_valid) begin
          if (stat.in_bad) begin
            state_next = ST_ERR;
          end else if (!stat.in_zero) begin
            cmd.load   = 1'b1;
            state_next = ST_DIV;
          end
        end
      end
      ST_DIV: begin
        if (stat.step_first && stat.quot_zero) begin
          state_next = ST_EMIT;
        end else begin
          cmd.div_step = 1'b1;
        end
      end
      ST_EMIT: begin
        if (stat.out_free) begin
          cmd.pop = 1'b1;
          if (stat.cnt_one) begin
            state_next = ST_IDLE;
          end
        end
      end
      ST_ERR: begin
        if (stat.out_free) begin
          cmd.err    = 1'b1;
          state_next = ST_IDLE;
        end
      end
      default: begin
        state_next = ST_IDLE;
      end
    endcase
  end

  always_ff @(posedge clk) begin
    if (rst) begin
      state <= ST_IDLE;
    end else begin
      state <= state_next;
    end
  end

endmodule

### hw/rtl/radix_digit_converter.sv
// radix_digit_converter: top level, converts a value to base 2..10 digits
// depends on rdc_pkg, rdc_ctrl, rdc_datapath
//
// input stream s_*: one transfer carries a value and a target base.
// output stream m_*: one transfer per digit, most significant first,
// m_tlast on the final digit. a zero value gives no transfer at all.
// a base outside 2..10 gives one transfer with digit 0, m_tlast and
// m_tuser set.
// each division by the base runs on one shared divider that retires
// 8 quotient bits per cycle. an item is divided in full before output
// starts; its digits then leave the digit stack ram one digit per
// cycle while m_tready stays high.
// s_tready is high only between items; the next item may enter while
// the final digit of the previous one is still held on m_*.
// when m_tready is low the current digit holds and output stops; no
// digit is lost. rst (synchronous) returns the block to idle with the
// output stream empty.
module radix_digit_converter
  import rdc_pkg::*;
#(
  parameter int unsigned VALUE_BITS = VALUE_BITS_DEF,
  localparam int unsigned IN_W      = ((VALUE_BITS + BASE_W + 7) / 8) * 8,
  localparam int unsigned OUT_W     = ((DIGIT_W + 7) / 8) * 8
) (
  input  logic             clk,
  input  logic             rst,
  input  logic             s_tvalid,
  output logic             s_tready,
  input  logic [IN_W-1:0]  s_tdata,   // value, base, zero fill
  output logic             m_tvalid,
  input  logic             m_tready,
  output logic [OUT_W-1:0] m_tdata,   // digit, zero fill
  output logic             m_tlast,
  output logic             m_tuser    // bad_base
);

  rdc_cmd_t           cmd;
  rdc_stat_t          stat;
  logic [DIGIT_W-1:0] digit;
  logic [BASE_W-1:0]  in_base;

  assign in_base = s_tdata[VALUE_BITS +: BASE_W];

  rdc_ctrl u_ctrl (
    .clk     (clk),
    .rst     (rst),
    .in_valid(s_tvalid),
    .in_ready(s_tready),
    .stat    (stat),
    .cmd     (cmd)
  );

  rdc_datapath #(
    .VALUE_BITS(VALUE_BITS)
  ) u_dp (
    .clk      (clk),
    .rst      (rst),
    .cmd      (cmd),
    .stat     (stat),
    .in_value (s_tdata[VALUE_BITS-1:0]),
    .in_base  (in_base),
    .out_ready(m_tready),
    .out_valid(m_tvalid),
    .out_digit(digit),
    .out_last (m_tlast),
    .out_bad  (m_tuser)
  );

  assign m_tdata = OUT_W'(digit);

  a_bad_is_last: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tuser |-> m_tlast && (digit == '0))
    else $error("error result without last or with nonzero digit");

  a_err_blocks_input: assert property (@(posedge clk) disable iff (rst)
    s_tvalid && s_tready && base_bad(in_base) |=> !s_tready)
    else $error("input taken while error result pending");

  a_digits_back_to_back: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && m_tready && !m_tlast |=> m_tvalid && !m_tuser)
    else $error("gap inside a digit run");

  a_no_input_mid_run: assert property (@(posedge clk) disable iff (rst)
    m_tvalid && !m_tlast |-> !s_tready)
    else $error("input ready while digits remain");

endmodule
